// File: rtl/core/obtp_pkg.sv
// shared types, sizes and codes for the opening book table probe
// no dependencies; imported by obtp_cell, the core and the testbench

package obtp_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int MAX_MATCHES = 32;

	localparam int ADDR_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int MATCH_W = $clog2(MAX_MATCHES + 1);

	localparam int KEY_W    = 64;
	localparam int MOVE_W   = 16;
	localparam int WEIGHT_W = 16;
	localparam int SQ_W     = 6;
	localparam int PROMO_W  = 3;
	localparam int BEST_W   = 5;
	localparam int STATUS_W = 3;
	localparam int ACTION_W = 2;

	// key compare is split into slices, one slice per cell
	localparam int SLICE_W   = 16;
	localparam int NUM_CELLS = KEY_W / SLICE_W;

	localparam logic [PROMO_W-1:0] PROMO_MAX = PROMO_W'(4);

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_PROBE = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE    = 3'd0,
		STAT_FULL    = 3'd1,
		STAT_NOMATCH = 3'd2,
		STAT_MATCH   = 3'd3,
		STAT_TRUNC   = 3'd4
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [MOVE_W-1:0]   move;
		logic [WEIGHT_W-1:0] weight;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// data handed from one compare cell to the next
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [KEY_W-1:0] probe;
		entry_t           ent;
	} cell_bus_t;

	// promotion codes above queen read as none
	function automatic logic [PROMO_W-1:0] decode_promo(input logic [PROMO_W-1:0] code);
		logic [PROMO_W-1:0] res;
		res = (code > PROMO_MAX) ? '0 : code;
		return res;
	endfunction

endpackage

// File: rtl/core/obtp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module obtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/obtp_cell.sv
// one key compare cell: checks the low key slice, rotates keys to the next slice
// depends on obtp_pkg

module obtp_cell
	import obtp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      flush,
	input  cell_bus_t bus_in,
	output cell_bus_t bus_out
);

	logic                vld_q;
	logic                hit_q;
	logic [KEY_W-1:0]    probe_q;
	logic [KEY_W-1:0]    key_q;
	logic [MOVE_W-1:0]   move_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic                slice_eq;

	assign slice_eq = (bus_in.ent.key[SLICE_W-1:0] == bus_in.probe[SLICE_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= bus_in.vld & ~flush;
		end
	end

	always_ff @(posedge clk) begin
		hit_q    <= bus_in.hit & slice_eq;
		// rotate so the next cell sees the next slice in the low bits
		probe_q  <= {bus_in.probe[SLICE_W-1:0], bus_in.probe[KEY_W-1:SLICE_W]};
		key_q    <= {bus_in.ent.key[SLICE_W-1:0], bus_in.ent.key[KEY_W-1:SLICE_W]};
		move_q   <= bus_in.ent.move;
		weight_q <= bus_in.ent.weight;
	end

	always_comb begin
		bus_out.vld        = vld_q;
		bus_out.hit        = hit_q;
		bus_out.probe      = probe_q;
		bus_out.ent.key    = key_q;
		bus_out.ent.move   = move_q;
		bus_out.ent.weight = weight_q;
	end

endmodule

// File: rtl/core/opening_book_table_probe_core.sv
// top level of the opening book table probe; depends on obtp_pkg, obtp_ram, obtp_cell
// clear, load and unused commands: result in the cycle after accept, a new command each cycle
// probe: busy from accept until the scan ends, and the last result appears as busy drops; one ram
//   read per stored entry, then the ram read register and the four-cell chain drain; a run cut
//   at the match limit ends early, an empty table answers in the cycle after accept
// results come one per cycle at most and cannot be held off; reset empties the table at once

module opening_book_table_probe_core
	import obtp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [ACTION_W-1:0]   action,
	input  logic [KEY_W-1:0]      position_key,
	input  logic [MOVE_W-1:0]     move_code,
	input  logic [WEIGHT_W-1:0]   move_weight,
	output logic                  strobe,
	output logic [STATUS_W-1:0]   status,
	output logic [SQ_W-1:0]       to_square,
	output logic [SQ_W-1:0]       from_square,
	output logic [PROMO_W-1:0]    promotion,
	output logic [WEIGHT_W-1:0]   match_weight,
	output logic [BEST_W-1:0]     best_index,
	output logic                  last
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic [KEY_W-1:0]    probe_q;
	logic                vld_s1;
	logic [MATCH_W-1:0]  n_q;
	logic [MOVE_W-1:0]   pend_move_q;
	logic [WEIGHT_W-1:0] pend_weight_q;
	logic [WEIGHT_W-1:0] best_w_q;
	logic [MATCH_W-1:0]  best_pos_q;

	logic                strobe_q;
	status_t             status_q;
	logic [MOVE_W-1:0]   res_move_q;
	logic [WEIGHT_W-1:0] res_weight_q;
	logic [BEST_W-1:0]   res_best_q;
	logic                res_last_q;

	logic                accept;
	logic                scanning;
	logic                full;
	logic                do_write;
	logic                issue;
	logic                issue_done;
	logic                chain_busy;
	logic                drained;
	logic                tail_hit;
	logic                drop;
	logic                finish;
	logic                take;
	logic                emit;
	status_t             e_status;
	logic [MOVE_W-1:0]   e_move;
	logic [WEIGHT_W-1:0] e_weight;
	logic [BEST_W-1:0]   e_best;
	logic                e_last;
	logic [ENTRY_W-1:0]  rd_data;
	entry_t              wr_entry;
	cell_bus_t           bus [NUM_CELLS+1];
	cell_bus_t           tail;

	assign accept   = start & ~busy;
	assign scanning = (state_q == S_SCAN);
	assign busy     = scanning;
	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign do_write = accept & (action == ACT_LOAD) & ~full;

	assign wr_entry.key    = position_key;
	assign wr_entry.move   = move_code;
	assign wr_entry.weight = move_weight;

	obtp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (do_write),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(wr_entry),
		.re   (issue),
		.raddr(rd_idx_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	always_comb begin
		bus[0].vld = vld_s1;
		bus[0].hit = 1'b1;
		bus[0].probe = probe_q;
		bus[0].ent = entry_t'(rd_data);
	end

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		obtp_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.flush  (finish),
			.bus_in (bus[g]),
			.bus_out(bus[g+1])
		);
	end

	assign tail = bus[NUM_CELLS];

	always_comb begin
		chain_busy = vld_s1;
		for (int i = 1; i <= NUM_CELLS; i++) begin
			chain_busy = chain_busy | bus[i].vld;
		end
	end

	assign issue_done = (rd_idx_q >= count_q);
	assign tail_hit   = scanning & tail.vld & tail.hit;
	assign drop       = tail_hit & (n_q == MATCH_W'(MAX_MATCHES));
	assign take       = tail_hit & ~drop;
	assign drained    = scanning & issue_done & ~chain_busy;
	assign finish     = drop | drained;
	assign issue      = scanning & ~issue_done & ~finish;

	// result selection
	always_comb begin
		emit     = 1'b0;
		e_status = STAT_DONE;
		e_move   = '0;
		e_weight = '0;
		e_best   = '0;
		e_last   = 1'b0;
		if (accept) begin
			emit   = 1'b1;
			e_last = 1'b1;
			case (action)
				ACT_LOAD: begin
					e_status = full ? STAT_FULL : STAT_DONE;
				end
				ACT_PROBE: begin
					// an empty table answers at once, otherwise the scan does
					emit     = (count_q == '0);
					e_status = STAT_NOMATCH;
				end
				default: begin
					e_status = STAT_DONE;
				end
			endcase
		end else if (finish) begin
			emit   = 1'b1;
			e_last = 1'b1;
			if (n_q == '0) begin
				e_status = STAT_NOMATCH;
			end else begin
				e_status = drop ? STAT_TRUNC : STAT_MATCH;
				e_move   = pend_move_q;
				e_weight = pend_weight_q;
				e_best   = BEST_W'(best_pos_q);
			end
		end else if (take && n_q != '0) begin
			// a newer match proves the held one is not the last
			emit     = 1'b1;
			e_status = STAT_MATCH;
			e_move   = pend_move_q;
			e_weight = pend_weight_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			n_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			vld_s1   <= issue;
			if (accept) begin
				case (action)
					ACT_CLEAR: begin
						count_q <= '0;
					end
					ACT_LOAD: begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
					ACT_PROBE: begin
						rd_idx_q <= '0;
						n_q      <= '0;
						if (count_q != '0) begin
							state_q <= S_SCAN;
						end
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end else if (scanning) begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (take) begin
					n_q <= n_q + 1'b1;
				end
				if (finish) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action == ACT_PROBE) begin
			probe_q <= position_key;
		end
		if (take) begin
			pend_move_q   <= tail.ent.move;
			pend_weight_q <= tail.ent.weight;
			if (n_q == '0 || tail.ent.weight > best_w_q) begin
				best_w_q   <= tail.ent.weight;
				best_pos_q <= n_q;
			end
		end
		if (emit) begin
			status_q     <= e_status;
			res_move_q   <= e_move;
			res_weight_q <= e_weight;
			res_best_q   <= e_best;
			res_last_q   <= e_last;
		end
	end

	assign strobe       = strobe_q;
	assign status       = status_q;
	assign to_square    = res_move_q[SQ_W-1:0];
	assign from_square  = res_move_q[2*SQ_W-1:SQ_W];
	assign promotion    = decode_promo(res_move_q[2*SQ_W+PROMO_W-1:2*SQ_W]);
	assign match_weight = res_weight_q;
	assign best_index   = res_best_q;
	assign last         = res_last_q;

endmodule

// File: tb/tb_opening_book_table_probe_core.sv
`timescale 1ns / 100ps
// self-checking testbench for opening_book_table_probe_core: clear, load, probe and unused traffic
// with a shadow copy of the book table that predicts every result
// depends on obtp_pkg and the block's rtl

module tb_opening_book_table_probe_core;
	import obtp_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;
	localparam logic [PROMO_W-1:0]  PROMO_QUEEN = 3'd4;
	localparam int RANDOM_ITEMS  = 140;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS   = 60;

	typedef struct {
		status_t             st;
		logic [SQ_W-1:0]     to_sq;
		logic [SQ_W-1:0]     from_sq;
		logic [PROMO_W-1:0]  promo;
		logic [WEIGHT_W-1:0] wt;
		logic [BEST_W-1:0]   best;
		logic                last;
	} book_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [ACTION_W-1:0] action;
	logic [KEY_W-1:0]    position_key;
	logic [MOVE_W-1:0]   move_code;
	logic [WEIGHT_W-1:0] move_weight;
	logic                strobe;
	logic [STATUS_W-1:0] status;
	logic [SQ_W-1:0]     to_square;
	logic [SQ_W-1:0]     from_square;
	logic [PROMO_W-1:0]  promotion;
	logic [WEIGHT_W-1:0] match_weight;
	logic [BEST_W-1:0]   best_index;
	logic                last;

	// shadow of the book table
	logic [KEY_W-1:0]    shadow_key    [TABLE_DEPTH];
	logic [MOVE_W-1:0]   shadow_move   [TABLE_DEPTH];
	logic [WEIGHT_W-1:0] shadow_weight [TABLE_DEPTH];
	int                  shadow_count;

	book_result_t pending_results [$];
	int           errors;
	int           results_seen;
	int           burst_left;
	bit           steady_run;

	opening_book_table_probe_core dut (
		.clk, .arst_n, .start, .busy, .action, .position_key, .move_code, .move_weight,
		.strobe, .status, .to_square, .from_square, .promotion, .match_weight,
		.best_index, .last
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("opening_book_table_probe_core regression: fail");
		$finish;
	end

	task automatic report(input string msg);
		if (errors < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic logic [KEY_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [MOVE_W-1:0] rand16();
		return MOVE_W'($urandom);
	endfunction

	function automatic void queue_result(input book_result_t r);
		pending_results = {pending_results, r};
	endfunction

	function automatic book_result_t plain_result(input status_t st);
		book_result_t r;
		r.st      = st;
		r.to_sq   = '0;
		r.from_sq = '0;
		r.promo   = '0;
		r.wt      = '0;
		r.best    = '0;
		r.last    = 1'b1;
		return r;
	endfunction

	// updates the shadow table and queues the results one command produces
	function automatic void predict_book_command(input logic [ACTION_W-1:0] act,
			input logic [KEY_W-1:0] key, input logic [MOVE_W-1:0] mv,
			input logic [WEIGHT_W-1:0] wt);
		book_result_t        run [$];
		book_result_t        r;
		int                  i;
		int                  n;
		int                  best_pos;
		bit                  dropped;
		logic [WEIGHT_W-1:0] best_wt;
		logic [PROMO_W-1:0]  code;
		n        = 0;
		best_pos = 0;
		dropped  = 1'b0;
		best_wt  = '0;
		case (act)
			ACT_CLEAR: begin
				shadow_count = 0;
				queue_result(plain_result(STAT_DONE));
			end
			ACT_LOAD: begin
				if (shadow_count >= TABLE_DEPTH) begin
					queue_result(plain_result(STAT_FULL));
				end else begin
					shadow_key[shadow_count]    = key;
					shadow_move[shadow_count]   = mv;
					shadow_weight[shadow_count] = wt;
					shadow_count++;
					queue_result(plain_result(STAT_DONE));
				end
			end
			ACT_PROBE: begin
				for (i = 0; i < shadow_count; i++) begin
					if (shadow_key[i] != key)
						continue;
					if (n >= MAX_MATCHES) begin
						dropped = 1'b1;
						break;
					end
					code      = shadow_move[i][2*SQ_W +: PROMO_W];
					r.st      = STAT_MATCH;
					r.to_sq   = shadow_move[i][0 +: SQ_W];
					r.from_sq = shadow_move[i][SQ_W +: SQ_W];
					r.promo   = (code > PROMO_QUEEN) ? '0 : code;
					r.wt      = shadow_weight[i];
					r.best    = '0;
					r.last    = 1'b0;
					// strict compare keeps the earliest of equal weights
					if (n == 0 || shadow_weight[i] > best_wt) begin
						best_wt  = shadow_weight[i];
						best_pos = n;
					end
					run = {run, r};
					n++;
				end
				if (n == 0) begin
					queue_result(plain_result(STAT_NOMATCH));
				end else begin
					if (dropped)
						run[n-1].st = STAT_TRUNC;
					run[n-1].best = BEST_W'(best_pos);
					run[n-1].last = 1'b1;
					foreach (run[j])
						queue_result(run[j]);
				end
			end
			default: begin
				queue_result(plain_result(STAT_DONE));
			end
		endcase
	endfunction

	always @(posedge clk) begin
		book_result_t want;
		if (arst_n && strobe) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d arrived with nothing outstanding", results_seen));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report($sformatf("result %0d status %0d, want %0d",
						results_seen, status, want.st));
				if (to_square !== want.to_sq)
					report($sformatf("result %0d to_square %0d, want %0d",
						results_seen, to_square, want.to_sq));
				if (from_square !== want.from_sq)
					report($sformatf("result %0d from_square %0d, want %0d",
						results_seen, from_square, want.from_sq));
				if (promotion !== want.promo)
					report($sformatf("result %0d promotion %0d, want %0d",
						results_seen, promotion, want.promo));
				if (match_weight !== want.wt)
					report($sformatf("result %0d match_weight %0d, want %0d",
						results_seen, match_weight, want.wt));
				if (best_index !== want.best)
					report($sformatf("result %0d best_index %0d, want %0d",
						results_seen, best_index, want.best));
				if (last !== want.last)
					report($sformatf("result %0d last %0b, want %0b",
						results_seen, last, want.last));
			end
		end
	end

	// drop start and put junk on the command fields, then wait
	task automatic idle_cycles(input int n);
		@(negedge clk);
		start        = 1'b0;
		action       = ACTION_W'($urandom);
		position_key = rand64();
		move_code    = rand16();
		move_weight  = rand16();
		repeat (n) @(posedge clk);
	endtask

	task automatic pace();
		if (steady_run)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_cycles($urandom_range(1, 6));
			burst_left = $urandom_range(0, 9);
		end
	endtask

	// one transaction: hold start until the block takes it
	task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
			input logic [MOVE_W-1:0] mv, input logic [WEIGHT_W-1:0] wt);
		@(negedge clk);
		start        = 1'b1;
		action       = act;
		position_key = key;
		move_code    = mv;
		move_weight  = wt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_book_command(act, key, mv, wt);
		pace();
	endtask

	task automatic test_empty_table();
		logic [KEY_W-1:0] k;
		k = rand64();
		send_cmd(ACT_PROBE, k, '0, '0);
		send_cmd(ACT_UNUSED, '1, '1, '1);
		send_cmd(ACT_PROBE, '1, '0, '0);
		send_cmd(ACT_CLEAR, '0, '0, '0);
		send_cmd(ACT_LOAD, k, rand16(), rand16());
		send_cmd(ACT_CLEAR, k, '1, '1);
		send_cmd(ACT_PROBE, k, '0, '0);
	endtask

	task automatic test_field_extremes();
		logic [KEY_W-1:0] k;
		int               p;
		k = rand64();
		send_cmd(ACT_CLEAR, '0, '0, '0);
		send_cmd(ACT_LOAD, '0, '0, '0);
		send_cmd(ACT_LOAD, '1, '1, '1);
		// promotion codes one to seven, the top three read as none
		for (p = 1; p < 8; p++)
			send_cmd(ACT_LOAD, k, {1'b0, p[2:0], 6'(p * 9), 6'(63 - p)}, 16'(p * 9000));
		send_cmd(ACT_PROBE, '0, '1, '1);
		send_cmd(ACT_PROBE, '1, '0, '0);
		send_cmd(ACT_PROBE, k, '0, '0);
		send_cmd(ACT_PROBE, k ^ 64'h1, '0, '0);
		send_cmd(ACT_PROBE, k ^ (64'h1 << 63), '0, '0);
		// unused action must leave the table alone
		send_cmd(ACT_UNUSED, k, '1, '1);
		send_cmd(ACT_PROBE, k, '0, '0);
	endtask

	task automatic test_weight_ties();
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] k2;
		k  = rand64();
		k2 = rand64();
		send_cmd(ACT_CLEAR, '0, '0, '0);
		send_cmd(ACT_LOAD, k, rand16(), 16'd5);
		send_cmd(ACT_LOAD, k2, rand16(), 16'd0);
		send_cmd(ACT_LOAD, k, rand16(), 16'd9);
		send_cmd(ACT_LOAD, k2, rand16(), 16'd0);
		send_cmd(ACT_LOAD, k, rand16(), 16'd9);
		send_cmd(ACT_LOAD, k, rand16(), 16'd3);
		send_cmd(ACT_LOAD, k2, rand16(), 16'd0);
		send_cmd(ACT_PROBE, k, '0, '0);
		send_cmd(ACT_PROBE, k2, '0, '0);
	endtask

	task automatic test_match_limit();
		logic [KEY_W-1:0] k;
		int               i;
		k = rand64();
		send_cmd(ACT_CLEAR, '0, '0, '0);
		for (i = 0; i < MAX_MATCHES; i++) begin
			if (i % 8 == 3)
				send_cmd(ACT_LOAD, rand64(), rand16(), rand16());
			send_cmd(ACT_LOAD, k, rand16(),
				(i == MAX_MATCHES - 1) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFE)));
		end
		send_cmd(ACT_PROBE, k, '0, '0);
		// one more match pushes the run past the limit
		send_cmd(ACT_LOAD, k, rand16(), 16'hFFFF);
		send_cmd(ACT_PROBE, k, '0, '0);
		send_cmd(ACT_LOAD, k, rand16(), rand16());
		send_cmd(ACT_PROBE, k, '0, '0);
	endtask

	task automatic test_table_full();
		logic [KEY_W-1:0] k;
		int               i;
		k = rand64();
		send_cmd(ACT_CLEAR, '0, '0, '0);
		for (i = 0; i < TABLE_DEPTH; i++) begin
			steady_run = (i >= TABLE_DEPTH / 2);
			send_cmd(ACT_LOAD, (i % 1000 == 0 || i == TABLE_DEPTH - 1) ? k : rand64(),
				rand16(), rand16());
		end
		steady_run = 1'b0;
		send_cmd(ACT_LOAD, k, rand16(), rand16());
		send_cmd(ACT_LOAD, rand64(), rand16(), rand16());
		send_cmd(ACT_PROBE, k, '0, '0);
		send_cmd(ACT_PROBE, rand64(), '0, '0);
		send_cmd(ACT_CLEAR, '0, '0, '0);
		send_cmd(ACT_PROBE, k, '0, '0);
		send_cmd(ACT_LOAD, k, rand16(), rand16());
		send_cmd(ACT_PROBE, k, '0, '0);
	endtask

	// loads and probes over a small key pool, with near-miss keys, unused commands and clears
	task automatic test_random_traffic();
		logic [KEY_W-1:0]    key_pool [4];
		logic [KEY_W-1:0]    k;
		logic [WEIGHT_W-1:0] w;
		int                  sent;
		int                  pick;
		for (pick = 0; pick < 4; pick++)
			key_pool[pick] = rand64();
		for (sent = 0; sent < RANDOM_ITEMS; sent++) begin
			if (sent % 25 == 0)
				steady_run = ($urandom_range(0, 2) == 0);
			k = key_pool[$urandom_range(0, 3)];
			case ($urandom_range(0, 9))
				0: k = rand64();
				1: k ^= 64'h1 << $urandom_range(0, 63);
				default: ;
			endcase
			w    = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
			pick = $urandom_range(0, 99);
			if (pick < 3 || shadow_count > 48)
				send_cmd(ACT_CLEAR, rand64(), rand16(), rand16());
			else if (pick < 6)
				send_cmd(ACT_UNUSED, k, rand16(), w);
			else if (pick < 58)
				send_cmd(ACT_LOAD, k, rand16(), w);
			else
				send_cmd(ACT_PROBE, k, rand16(), rand16());
		end
		steady_run = 1'b0;
	endtask

	initial begin
		int guard;
		arst_n       = 1'b0;
		start        = 1'b0;
		action       = ACT_CLEAR;
		position_key = '0;
		move_code    = '0;
		move_weight  = '0;
		shadow_count = 0;
		errors       = 0;
		results_seen = 0;
		burst_left   = 0;
		steady_run   = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_field_extremes();
		test_weight_ties();
		test_match_limit();
		test_table_full();
		test_random_traffic();

		@(negedge clk);
		start = 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report($sformatf("%0d expected results never arrived", pending_results.size()));

		if (errors == 0)
			$display("opening_book_table_probe_core regression: pass");
		else
			$display("opening_book_table_probe_core regression: fail");
		$finish;
	end

endmodule
